// File: hdl/es2cal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_pkg
// Shared constants, command/status types and the month length table for the
// epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package es2cal_pkg;

   localparam int DEF_STAMP_BITS = 32;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

   // whole years and whole months in seconds
   localparam int          YEAR_SECS_BITS  = 25;
   localparam logic [24:0] PLAIN_YEAR_SECS = 25'd31536000;
   localparam logic [24:0] LEAP_YEAR_SECS  = 25'd31622400;
   localparam logic [21:0] SECS_28_DAYS    = 22'd2419200;
   localparam logic [21:0] SECS_29_DAYS    = 22'd2505600;
   localparam logic [21:0] SECS_30_DAYS    = 22'd2592000;
   localparam logic [21:0] SECS_31_DAYS    = 22'd2678400;

   // floor(x / d) as (x * recip) >> shift, exact over each operand range
   // day:    (seconds of month >> 7) / 675, 15-bit operand, shift 25
   // hour:   (seconds of day >> 4) / 225, 13-bit operand, shift 21
   // minute: (seconds of hour >> 2) / 15, 10-bit operand, shift 14
   localparam logic [15:0] DAY_RECIP  = 16'd49711;
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [10:0] MIN_RECIP  = 11'd1093;

   localparam logic [11:0] FIRST_YEAR      = 12'd1970;
   // 1970 mod 4, mod 100, mod 400
   localparam logic [1:0]  FIRST_YEAR_M4   = 2'd2;
   localparam logic [6:0]  FIRST_YEAR_M100 = 7'd70;
   localparam logic [8:0]  FIRST_YEAR_M400 = 9'd370;
   localparam logic [6:0]  LAST_M100       = 7'd99;
   localparam logic [8:0]  LAST_M400       = 9'd399;

   localparam logic [3:0]  MONTH_JAN = 4'd1;
   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [3:0]  MONTH_MAR = 4'd3;
   localparam logic [3:0]  MONTH_APR = 4'd4;
   localparam logic [3:0]  MONTH_MAY = 4'd5;
   localparam logic [3:0]  MONTH_JUN = 4'd6;
   localparam logic [3:0]  MONTH_JUL = 4'd7;
   localparam logic [3:0]  MONTH_AUG = 4'd8;
   localparam logic [3:0]  MONTH_SEP = 4'd9;
   localparam logic [3:0]  MONTH_OCT = 4'd10;
   localparam logic [3:0]  MONTH_NOV = 4'd11;
   localparam logic [3:0]  MONTH_DEC = 4'd12;

   typedef struct packed {
      logic start;
      logic year_step;
      logic month_step;
      logic day_quo;
      logic day_rem;
      logic hour_quo;
      logic hour_rem;
      logic min_quo;
      logic min_rem;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } status_type;

   function automatic logic [21:0] month_secs(input logic [3:0] month, input logic leap);
      logic [21:0] len;
      unique case (month)
         MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
         MONTH_AUG, MONTH_OCT, MONTH_DEC: len = SECS_31_DAYS;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = SECS_30_DAYS;
         MONTH_FEB: len = leap ? SECS_29_DAYS : SECS_28_DAYS;
         default: len = SECS_31_DAYS;
      endcase
      return len;
   endfunction

endpackage

// File: hdl/es2cal_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_dp
// Datapath: year and month subtractors on the second count with leap
// tracking, reciprocal multiply splits into day, hour, minute and second,
// and the result register.
// ----------------------------------------------------------------------------
module es2cal_dp #(
   parameter int STAMP_BITS = es2cal_pkg::DEF_STAMP_BITS
) (
   input  logic                   clock,
   input  logic [STAMP_BITS-1:0]  req_epoch_seconds,
   input  es2cal_pkg::cmd_type    cmd,
   output es2cal_pkg::status_type status,
   output logic [11:0]            rsp_year,
   output logic [3:0]             rsp_month,
   output logic [4:0]             rsp_day_of_month,
   output logic [4:0]             rsp_hour,
   output logic [5:0]             rsp_minute,
   output logic [5:0]             rsp_second
);

   localparam int SW = (STAMP_BITS > es2cal_pkg::YEAR_SECS_BITS) ? STAMP_BITS :
                       es2cal_pkg::YEAR_SECS_BITS;

   logic [STAMP_BITS-1:0] secs_ff, secs_in;
   logic [11:0]           year_ff, year_in;
   logic [1:0]            y4_ff, y4_in;
   logic [6:0]            y100_ff, y100_in;
   logic [8:0]            y400_ff, y400_in;
   logic [3:0]            month_ff, month_in;
   logic [4:0]            day_ff, day_in;
   logic [16:0]           sod_ff, sod_in;
   logic [4:0]            hour_ff, hour_in;
   logic [11:0]           soh_ff, soh_in;
   logic [5:0]            minute_ff, minute_in;
   logic [5:0]            second_ff, second_in;

   logic [11:0] out_year_ff;
   logic [3:0]  out_month_ff;
   logic [4:0]  out_day_ff;
   logic [4:0]  out_hour_ff;
   logic [5:0]  out_minute_ff;
   logic [5:0]  out_second_ff;

   logic [SW-1:0] secs_x;
   logic          leap;
   logic [24:0]   ylen;
   logic [21:0]   mlen;
   logic [29:0]   day_prod;
   logic [25:0]   hour_prod;
   logic [19:0]   min_prod;
   logic [21:0]   day_secs;
   logic [16:0]   hour_secs;
   logic [11:0]   min_secs;

   assign secs_x = SW'(secs_ff);

   // gregorian rule from running residues of the year
   assign leap = (y400_ff == '0) || ((y100_ff != '0) && (y4_ff == '0));
   assign ylen = leap ? es2cal_pkg::LEAP_YEAR_SECS : es2cal_pkg::PLAIN_YEAR_SECS;
   assign mlen = es2cal_pkg::month_secs(month_ff, leap);

   assign status.year_done  = (secs_x < SW'(ylen));
   assign status.month_done = (month_ff == es2cal_pkg::MONTH_DEC) ||
                              (secs_x < SW'(mlen));

   // quotients sit in the top bits of the reciprocal products
   assign day_prod  = 30'(secs_x[21:7]) * 30'(es2cal_pkg::DAY_RECIP);
   assign hour_prod = 26'(sod_ff[16:4]) * 26'(es2cal_pkg::HOUR_RECIP);
   assign min_prod  = 20'(soh_ff[11:2]) * 20'(es2cal_pkg::MIN_RECIP);

   assign day_secs  = 22'(day_ff) * 22'(es2cal_pkg::SECS_PER_DAY);
   assign hour_secs = 17'(hour_ff) * 17'(es2cal_pkg::SECS_PER_HOUR);
   assign min_secs  = 12'(minute_ff) * 12'(es2cal_pkg::SECS_PER_MIN);

   always_comb begin
      secs_in   = secs_ff;
      year_in   = year_ff;
      y4_in     = y4_ff;
      y100_in   = y100_ff;
      y400_in   = y400_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      sod_in    = sod_ff;
      hour_in   = hour_ff;
      soh_in    = soh_ff;
      minute_in = minute_ff;
      second_in = second_ff;

      if (cmd.start) begin
         secs_in  = req_epoch_seconds;
         year_in  = es2cal_pkg::FIRST_YEAR;
         y4_in    = es2cal_pkg::FIRST_YEAR_M4;
         y100_in  = es2cal_pkg::FIRST_YEAR_M100;
         y400_in  = es2cal_pkg::FIRST_YEAR_M400;
         month_in = es2cal_pkg::MONTH_JAN;
      end

      if (cmd.year_step) begin
         secs_in = STAMP_BITS'(secs_x - SW'(ylen));
         year_in = year_ff + 12'd1;
         y4_in   = y4_ff + 2'd1;
         y100_in = (y100_ff == es2cal_pkg::LAST_M100) ? '0 : y100_ff + 7'd1;
         y400_in = (y400_ff == es2cal_pkg::LAST_M400) ? '0 : y400_ff + 9'd1;
      end

      if (cmd.month_step) begin
         secs_in  = STAMP_BITS'(secs_x - SW'(mlen));
         month_in = month_ff + 4'd1;
      end

      // less than 31 days of seconds are left once the month is found
      if (cmd.day_quo) begin
         day_in = day_prod[29:25];
      end
      if (cmd.day_rem) begin
         sod_in = 17'(secs_x[21:0] - day_secs);
      end
      if (cmd.hour_quo) begin
         hour_in = hour_prod[25:21];
      end
      if (cmd.hour_rem) begin
         soh_in = 12'(sod_ff - hour_secs);
      end
      if (cmd.min_quo) begin
         minute_in = min_prod[19:14];
      end
      if (cmd.min_rem) begin
         second_in = 6'(soh_ff - min_secs);
      end
   end

   always_ff @(posedge clock) begin
      secs_ff   <= secs_in;
      year_ff   <= year_in;
      y4_ff     <= y4_in;
      y100_ff   <= y100_in;
      y400_ff   <= y400_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      sod_ff    <= sod_in;
      hour_ff   <= hour_in;
      soh_ff    <= soh_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      if (cmd.load_out) begin
         out_year_ff   <= year_ff;
         out_month_ff  <= month_ff;
         out_day_ff    <= day_ff + 5'd1;
         out_hour_ff   <= hour_ff;
         out_minute_ff <= minute_ff;
         out_second_ff <= second_ff;
      end
   end

   assign rsp_year         = out_year_ff;
   assign rsp_month        = out_month_ff;
   assign rsp_day_of_month = out_day_ff;
   assign rsp_hour         = out_hour_ff;
   assign rsp_minute       = out_minute_ff;
   assign rsp_second       = out_second_ff;

endmodule

// File: hdl/es2cal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_ctrl
// Sequencer: runs the year and month loops and the day, hour and minute
// splits, then hands the result to the output register.
// ----------------------------------------------------------------------------
module es2cal_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  es2cal_pkg::status_type status,
   output es2cal_pkg::cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_YEARS  = 10'b0000000010,
      ST_MONTHS = 10'b0000000100,
      ST_DAY_Q  = 10'b0000001000,
      ST_DAY_R  = 10'b0000010000,
      ST_HOUR_Q = 10'b0000100000,
      ST_HOUR_R = 10'b0001000000,
      ST_MIN_Q  = 10'b0010000000,
      ST_MIN_R  = 10'b0100000000,
      ST_FINISH = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_YEARS;
            end
         end
         ST_YEARS: begin
            if (status.year_done) begin
               state_in = ST_MONTHS;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         ST_MONTHS: begin
            if (status.month_done) begin
               state_in = ST_DAY_Q;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         ST_DAY_Q: begin
            cmd.day_quo = 1'b1;
            state_in    = ST_DAY_R;
         end
         ST_DAY_R: begin
            cmd.day_rem = 1'b1;
            state_in    = ST_HOUR_Q;
         end
         ST_HOUR_Q: begin
            cmd.hour_quo = 1'b1;
            state_in     = ST_HOUR_R;
         end
         ST_HOUR_R: begin
            cmd.hour_rem = 1'b1;
            state_in     = ST_MIN_Q;
         end
         ST_MIN_Q: begin
            cmd.min_quo = 1'b1;
            state_in    = ST_MIN_R;
         end
         ST_MIN_R: begin
            cmd.min_rem = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // wait until the previous transaction has left the output register
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts seconds since 1970-01-01 00:00:00 UTC into the Gregorian date and
// the time of day. The req_ channel carries one unsigned stamp per
// transaction; the rsp_ channel returns year, month, day of month, hour,
// minute and second. A transaction moves on a rising edge with valid high and
// stall low. Only the low STAMP_BITS bits of the stamp are used; the year
// field wraps modulo 4096.
// One transaction is processed at a time: req_stall is high from acceptance
// until the result is written to the output register, and the next stamp is
// taken only once the sequencer is back in idle. The year and month loops
// take one year or month of seconds off per cycle; the states DAY_Q, DAY_R,
// HOUR_Q, HOUR_R, MIN_Q and MIN_R then split the rest into days, hours,
// minutes and seconds by reciprocal multiplication.
// A finished result waits in the output register while rsp_stall is high;
// the next stamp is accepted and worked on meanwhile and holds at its end
// until the register is free.
// Reset is synchronous: it returns the sequencer to idle and drops
// rsp_valid. The datapath and output registers are not reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top #(
   parameter int STAMP_BITS = es2cal_pkg::DEF_STAMP_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [STAMP_BITS-1:0] req_epoch_seconds,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [11:0]           rsp_year,
   output logic [3:0]            rsp_month,
   output logic [4:0]            rsp_day_of_month,
   output logic [4:0]            rsp_hour,
   output logic [5:0]            rsp_minute,
   output logic [5:0]            rsp_second
);

   es2cal_pkg::cmd_type    cmd;
   es2cal_pkg::status_type status;

   es2cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   es2cal_dp #(
      .STAMP_BITS (STAMP_BITS)
   ) u_dp (
      .clock             (clock),
      .req_epoch_seconds (req_epoch_seconds),
      .cmd               (cmd),
      .status            (status),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second)
   );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for epoch_seconds_to_calendar_top. A short table of
// stamps comes first (epoch start, unit boundaries, leap and century days,
// the top of the 32-bit range), then random stamps, uniform over the range,
// on day, month and year boundaries, or near either end. Each accepted stamp
// queues the expected date and time, and each result is checked field by
// field against the oldest entry. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          STAMP_W      = 32;
   localparam int          RANDOM_ITEMS = 1326;
   localparam int          TAIL_CYCLES  = 250;
   localparam int          CYCLE_LIMIT  = 5000000;
   localparam int unsigned DAY_SECS     = 86400;
   localparam int unsigned HOUR_SECS    = 3600;
   localparam int unsigned MIN_SECS     = 60;
   localparam int unsigned EPOCH_YEAR   = 1970;
   localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cal_type;

   typedef struct packed {
      logic [31:0] stamp;
      logic        typed;
      cal_type     want;
   } row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam row_type DIRECTED [DIRECTED_ROWS] = '{
      '{32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
      '{32'd1,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd1}},
      '{32'd59,         1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd59}},
      '{32'd60,         1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd1,  6'd0}},
      '{32'd3599,       1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd59, 6'd59}},
      '{32'd3600,       1'b1, '{12'd1970, 4'd1,  5'd1,  5'd1,  6'd0,  6'd0}},
      '{32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59}},
      '{32'd86400,      1'b1, '{12'd1970, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0}},
      '{32'd2678400,    1'b1, '{12'd1970, 4'd2,  5'd1,  5'd0,  6'd0,  6'd0}},
      '{32'd31535999,   1'b1, '{12'd1970, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
      '{32'd31536000,   1'b1, '{12'd1971, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
      '{32'hFFFFFFFF,   1'b1, '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15}},
      '{32'd68169600,   1'b0, '0},
      '{32'd68255999,   1'b0, '0},
      '{32'd951782400,  1'b0, '0},
      '{32'd951868800,  1'b0, '0},
      '{32'd946684799,  1'b0, '0},
      '{32'd4107456000, 1'b0, '0},
      '{32'd4107542400, 1'b0, '0},
      '{32'h7FFFFFFF,   1'b0, '0},
      '{32'h80000000,   1'b0, '0},
      '{32'hAAAAAAAA,   1'b0, '0},
      '{32'h55555555,   1'b0, '0},
      '{32'd4294944000, 1'b0, '0}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [STAMP_W-1:0] req_epoch_seconds;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [11:0]        rsp_year;
   logic [3:0]         rsp_month;
   logic [4:0]         rsp_day_of_month;
   logic [4:0]         rsp_hour;
   logic [5:0]         rsp_minute;
   logic [5:0]         rsp_second;

   cal_type pending_dates [$];
   int      fail_count  = 0;
   int      sent_count  = 0;
   int      cycle_count = 0;
   logic    calm        = 1'b0;

   epoch_seconds_to_calendar_top #(
      .STAMP_BITS(STAMP_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_epoch_seconds(req_epoch_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic bit is_leap(input int unsigned yr);
      return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
   endfunction

   // walk whole years, then whole months, off the day count
   function automatic cal_type to_calendar(input logic [31:0] stamp);
      cal_type     c;
      int unsigned days, secs, yr, mon, mlen;
      days = stamp / DAY_SECS;
      secs = stamp % DAY_SECS;
      yr   = EPOCH_YEAR;
      mon  = 1;
      while (days >= (is_leap(yr) ? 366 : 365)) begin
         days = days - (is_leap(yr) ? 366 : 365);
         yr++;
      end
      while (mon < 12) begin
         mlen = MONTH_LEN[mon-1] + ((mon == 2 && is_leap(yr)) ? 1 : 0);
         if (days < mlen) break;
         days = days - mlen;
         mon++;
      end
      c.year   = yr[11:0];
      c.month  = mon[3:0];
      c.day    = 5'(days + 1);
      c.hour   = 5'(secs / HOUR_SECS);
      c.minute = 6'((secs % HOUR_SECS) / MIN_SECS);
      c.second = 6'(secs % MIN_SECS);
      return c;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(20, 4);
      return $urandom_range(300, 50);
   endfunction

   task automatic send_stamp(input logic [31:0] stamp, input cal_type want);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= stamp;
      do @(posedge clock); while (req_stall);
      pending_dates.push_back(want);
      sent_count++;
      calm = (sent_count >= 400) && (sent_count < 560);
   endtask

   // result side back pressure
   initial begin
      int n;
      rsp_stall = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         n = calm ? 0 : pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (calm ? 1 : $urandom_range(8, 1)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cal_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dates.size() == 0) begin
            $error("result with no transaction outstanding: %0d-%0d-%0d %0d:%0d:%0d",
                   rsp_year, rsp_month, rsp_day_of_month, rsp_hour, rsp_minute, rsp_second);
            fail_count++;
         end else begin
            want = pending_dates.pop_front();
            if (rsp_year !== want.year) begin
               $error("year: expected %0d, got %0d", want.year, rsp_year);
               fail_count++;
            end
            if (rsp_month !== want.month) begin
               $error("month: expected %0d, got %0d", want.month, rsp_month);
               fail_count++;
            end
            if (rsp_day_of_month !== want.day) begin
               $error("day_of_month: expected %0d, got %0d", want.day, rsp_day_of_month);
               fail_count++;
            end
            if (rsp_hour !== want.hour) begin
               $error("hour: expected %0d, got %0d", want.hour, rsp_hour);
               fail_count++;
            end
            if (rsp_minute !== want.minute) begin
               $error("minute: expected %0d, got %0d", want.minute, rsp_minute);
               fail_count++;
            end
            if (rsp_second !== want.second) begin
               $error("second: expected %0d, got %0d", want.second, rsp_second);
               fail_count++;
            end
         end
      end
   end

   initial begin
      logic [31:0] stamp;
      int          mode;
      int unsigned yr, mon, days;
      longint      wide;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_epoch_seconds = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_stamp(DIRECTED[i].stamp,
                    DIRECTED[i].typed ? DIRECTED[i].want : to_calendar(DIRECTED[i].stamp));
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         mode = $urandom_range(99, 0);
         if (mode < 55) begin
            stamp = $urandom;
         end else if (mode < 80) begin
            // around midnight of a random day, or anywhere within it
            days = $urandom_range(49710, 0);
            case ($urandom_range(4, 0))
               0: wide = longint'(days) * DAY_SECS;
               1: wide = longint'(days) * DAY_SECS + 1;
               2: wide = longint'(days) * DAY_SECS + DAY_SECS - 1;
               3: wide = longint'(days) * DAY_SECS + DAY_SECS - 2;
               default: wide = longint'(days) * DAY_SECS + $urandom_range(DAY_SECS - 1, 0);
            endcase
            stamp = wide[31:0];
         end else if (mode < 92) begin
            // first second of a month, or the last second before it
            yr   = $urandom_range(2106, EPOCH_YEAR);
            mon  = $urandom_range(12, 1);
            days = 0;
            for (int y = EPOCH_YEAR; y < yr; y++) days += is_leap(y) ? 366 : 365;
            for (int m = 1; m < mon; m++) begin
               days += MONTH_LEN[m-1] + ((m == 2 && is_leap(yr)) ? 1 : 0);
            end
            wide = longint'(days) * DAY_SECS - $urandom_range(1, 0);
            if (wide < 0) wide = 0;
            stamp = wide[31:0];
         end else if (mode < 96) begin
            stamp = $urandom_range(100000, 0);
         end else begin
            stamp = 32'hFFFFFFFF - $urandom_range(3000000, 0);
         end
         send_stamp(stamp, to_calendar(stamp));
      end
      req_valid <= 1'b0;

      while (pending_dates.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
